>>> design/thumb_data_processing_execute_core_defines.svh
// Assertion helpers for the data-processing execute core.
`ifndef THUMB_DATA_PROCESSING_EXECUTE_CORE_DEFINES_SVH
`define THUMB_DATA_PROCESSING_EXECUTE_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define TDPE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tdpe: same-cycle check failed");

// Next-cycle implication, clocked on clk_i, off during reset.
`define TDPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tdpe: next-cycle check failed");

`endif

>>> design/tdpe_pkg.sv
package tdpe_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned RegIdxW  = 4;
  localparam int unsigned NumRegs  = 15;

  localparam logic [RegIdxW-1:0] PcIdx = 4'd15;
  localparam logic [RegIdxW-1:0] SpIdx = 4'd13;

  localparam logic [WordBits-1:0] HalfLanes = 32'h00FF00FF;
  localparam logic [WordBits-1:0] ByteMask  = 32'h000000FF;
  localparam logic [WordBits-1:0] HalfMask  = 32'h0000FFFF;

  localparam logic [7:0] ShiftWord = 8'd32;

  typedef enum logic [5:0] {
    OP_MOV_IMM     = 6'd0,
    OP_MOV_REG     = 6'd1,
    OP_MOV_REG_HI  = 6'd2,
    OP_LSL_IMM     = 6'd3,
    OP_LSR_IMM     = 6'd4,
    OP_ASR_IMM     = 6'd5,
    OP_LSL_REG     = 6'd6,
    OP_LSR_REG     = 6'd7,
    OP_ASR_REG     = 6'd8,
    OP_ROR_REG     = 6'd9,
    OP_ADD_REG     = 6'd10,
    OP_ADD_IMM     = 6'd11,
    OP_SUB_REG     = 6'd12,
    OP_SUB_IMM     = 6'd13,
    OP_ADC         = 6'd14,
    OP_SBC         = 6'd15,
    OP_RSB         = 6'd16,
    OP_ADD_REG_HI  = 6'd17,
    OP_CMP_IMM     = 6'd18,
    OP_CMP_REG     = 6'd19,
    OP_CMN         = 6'd20,
    OP_AND         = 6'd21,
    OP_EOR         = 6'd22,
    OP_ORR         = 6'd23,
    OP_BIC         = 6'd24,
    OP_MVN         = 6'd25,
    OP_TST         = 6'd26,
    OP_MUL         = 6'd27,
    OP_ADR         = 6'd28,
    OP_ADD_SP_IMM  = 6'd29,
    OP_ADD_SP_SP   = 6'd30,
    OP_SUB_SP_IMM  = 6'd31,
    OP_SXTB        = 6'd32,
    OP_SXTH        = 6'd33,
    OP_UXTB        = 6'd34,
    OP_UXTH        = 6'd35,
    OP_REV         = 6'd36,
    OP_REV16       = 6'd37,
    OP_REVSH       = 6'd38
  } op_e;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_e;

  typedef enum logic {
    ST_OK    = 1'b0,
    ST_UNDEF = 1'b1
  } status_e;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

endpackage

>>> design/thumb_data_processing_execute_core.sv
// Executes one ARMv6-M Thumb data-processing instruction per transfer and
// sustains one instruction per cycle while the output side does not
// stall. Each instruction passes through an input register, where the
// register-file operands have already been read, and then into a result
// register, which it enters when the output side does not stall. The cycle
// is set by the operand path through the shifter, the 32-bit adder or the
// 32x32 low multiplier. Registers r0-r14 live in a 15-entry memory with
// two read ports, read at input transfer with a bypass from the
// instruction that retires in the same cycle; per-entry valid bits make
// every register read as zero after reset, so no clearing pass is needed.
// The register file and flags commit when an instruction moves into the
// result register, so a stalled output holds all state.
`include "thumb_data_processing_execute_core_defines.svh"

module thumb_data_processing_execute_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [5:0]  opcode_i,
  input  logic [3:0]  dest_reg_i,
  input  logic [3:0]  first_reg_i,
  input  logic [3:0]  second_reg_i,
  input  logic [31:0] immediate_i,
  input  logic        update_flags_i,
  input  logic [31:0] instr_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_value_o,
  output logic [3:0]  flags_out_o,
  output logic        pc_written_o,
  output logic        exec_status_o
);
  import tdpe_pkg::*;

  logic                in_fire;
  logic                advance;
  logic                s1_valid_q;
  logic                out_valid_q;

  logic [5:0]          op_q;
  logic [RegIdxW-1:0]  rd_q;
  logic [RegIdxW-1:0]  rn_q;
  logic [RegIdxW-1:0]  rm_q;
  logic [31:0]         imm_q;
  logic                sf_q;
  logic [31:0]         pc_q;

  logic [31:0]         rf_mem [NumRegs];
  logic [15:0]         vld_q;
  logic [RegIdxW-1:0]  addr_a;
  logic [31:0]         mem_a_q;
  logic [31:0]         mem_b_q;
  logic                vld_a_q;
  logic                vld_b_q;
  logic                fwd_a_q;
  logic                fwd_b_q;
  logic [31:0]         fwd_data_q;

  logic                wr_en;
  logic [RegIdxW-1:0]  wr_addr;
  logic [31:0]         wr_data;

  flags_t              flags_q;
  flags_t              flags_d;

  logic [31:0]         pc4;
  logic [31:0]         rf_a;
  logic [31:0]         rf_b;
  logic [31:0]         a;
  logic [31:0]         b;

  shift_e              sh_kind;
  logic [31:0]         sh_x;
  logic [7:0]          sh_amt;
  logic [7:0]          imm_amt;
  logic [31:0]         sh_val;
  logic                sh_c;
  logic [32:0]         lsl_ext;
  logic [32:0]         lsr_ext;
  logic [32:0]         asr_ext;
  logic [63:0]         ror_ext;

  logic [31:0]         add_a;
  logic [31:0]         add_b;
  logic                add_cin;
  logic [32:0]         add_sum;
  logic                add_v;

  logic [31:0]         mul_lo;

  logic [31:0]         val;
  logic                write;
  logic                to_sp;
  logic                set_nz;
  logic                set_c;
  logic                set_v;
  logic                known;
  logic [31:0]         res_d;
  logic                pcw_d;

  logic [31:0]         result_q;
  logic [3:0]          flags_out_q;
  logic                pcw_q;
  status_e             status_q;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  assign addr_a = ((opcode_i == OP_ADD_SP_IMM) || (opcode_i == OP_ADD_SP_SP) ||
                   (opcode_i == OP_SUB_SP_IMM)) ? SpIdx : first_reg_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      flags_q     <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        flags_q     <= flags_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rf_mem[wr_addr] <= wr_data;
    end
    if (in_fire) begin
      op_q       <= opcode_i;
      rd_q       <= dest_reg_i;
      rn_q       <= addr_a;
      rm_q       <= second_reg_i;
      imm_q      <= immediate_i;
      sf_q       <= update_flags_i;
      pc_q       <= instr_address_i;
      mem_a_q    <= rf_mem[addr_a];
      mem_b_q    <= rf_mem[second_reg_i];
      vld_a_q    <= vld_q[addr_a];
      vld_b_q    <= vld_q[second_reg_i];
      fwd_a_q    <= wr_en && (wr_addr == addr_a);
      fwd_b_q    <= wr_en && (wr_addr == second_reg_i);
      fwd_data_q <= wr_data;
    end
  end

  assign pc4  = pc_q + 32'd4;
  assign rf_a = fwd_a_q ? fwd_data_q : (vld_a_q ? mem_a_q : '0);
  assign rf_b = fwd_b_q ? fwd_data_q : (vld_b_q ? mem_b_q : '0);
  assign a    = (rn_q == PcIdx) ? pc4 : rf_a;
  assign b    = (rm_q == PcIdx) ? pc4 : rf_b;

  assign imm_amt = (|imm_q[31:8]) ? 8'hFF : imm_q[7:0];

  always_comb begin
    sh_kind = SH_LSL;
    sh_x    = b;
    sh_amt  = imm_amt;
    add_a   = a;
    add_b   = b;
    add_cin = 1'b0;
    case (op_q)
      OP_LSL_IMM: begin
        sh_kind = SH_LSL;
      end
      OP_LSR_IMM: begin
        sh_kind = SH_LSR;
        sh_amt  = (imm_q == '0) ? ShiftWord : imm_amt;
      end
      OP_ASR_IMM: begin
        sh_kind = SH_ASR;
        sh_amt  = (imm_q == '0) ? ShiftWord : imm_amt;
      end
      OP_LSL_REG, OP_LSR_REG, OP_ASR_REG, OP_ROR_REG: begin
        sh_kind = shift_e'(op_q[1:0] - 2'd2);
        sh_x    = a;
        sh_amt  = b[7:0];
      end
      OP_ADD_IMM, OP_ADD_SP_IMM, OP_ADD_SP_SP: begin
        add_b = imm_q;
      end
      OP_SUB_REG, OP_CMP_REG: begin
        add_b   = ~b;
        add_cin = 1'b1;
      end
      OP_SUB_IMM, OP_CMP_IMM, OP_SUB_SP_IMM: begin
        add_b   = ~imm_q;
        add_cin = 1'b1;
      end
      OP_ADC: begin
        add_cin = flags_q.c;
      end
      OP_SBC: begin
        add_b   = ~b;
        add_cin = flags_q.c;
      end
      OP_RSB: begin
        add_a   = ~a;
        add_b   = '0;
        add_cin = 1'b1;
      end
      OP_ADR: begin
        add_a = {pc4[31:2], 2'b00};
        add_b = imm_q;
      end
      default: begin
      end
    endcase
  end

  assign lsl_ext = {1'b0, sh_x} << sh_amt[4:0];
  assign lsr_ext = {sh_x, 1'b0} >> sh_amt[4:0];
  assign asr_ext = 33'($signed({sh_x, 1'b0}) >>> sh_amt[4:0]);
  assign ror_ext = {sh_x, sh_x} >> sh_amt[4:0];

  always_comb begin
    sh_val = sh_x;
    sh_c   = flags_q.c;
    if (sh_amt != '0) begin
      case (sh_kind)
        SH_LSL: begin
          if (sh_amt < ShiftWord) begin
            sh_val = lsl_ext[31:0];
            sh_c   = lsl_ext[32];
          end else begin
            sh_val = '0;
            sh_c   = (sh_amt == ShiftWord) ? sh_x[0] : 1'b0;
          end
        end
        SH_LSR: begin
          if (sh_amt < ShiftWord) begin
            sh_val = lsr_ext[32:1];
            sh_c   = lsr_ext[0];
          end else begin
            sh_val = '0;
            sh_c   = (sh_amt == ShiftWord) ? sh_x[31] : 1'b0;
          end
        end
        SH_ASR: begin
          if (sh_amt < ShiftWord) begin
            sh_val = asr_ext[32:1];
            sh_c   = asr_ext[0];
          end else begin
            sh_val = {32{sh_x[31]}};
            sh_c   = sh_x[31];
          end
        end
        default: begin
          sh_val = ror_ext[31:0];
          sh_c   = ror_ext[31];
        end
      endcase
    end
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
  assign add_v   = (add_a[31] ^ add_sum[31]) & (add_b[31] ^ add_sum[31]);
  assign mul_lo  = a * b;

  always_comb begin
    val     = '0;
    write   = 1'b1;
    to_sp   = 1'b0;
    set_nz  = 1'b0;
    set_c   = 1'b0;
    set_v   = 1'b0;
    known   = 1'b1;
    case (op_q)
      OP_MOV_IMM: begin
        val    = imm_q;
        set_nz = sf_q;
      end
      OP_MOV_REG: begin
        val    = b;
        set_nz = sf_q;
      end
      OP_MOV_REG_HI: begin
        val = b;
      end
      OP_LSL_IMM, OP_LSR_IMM, OP_ASR_IMM, OP_LSL_REG, OP_LSR_REG, OP_ASR_REG,
      OP_ROR_REG: begin
        val    = sh_val;
        set_nz = sf_q;
        set_c  = sf_q;
      end
      OP_ADD_REG, OP_ADD_IMM, OP_SUB_REG, OP_SUB_IMM, OP_ADC, OP_SBC, OP_RSB: begin
        val    = add_sum[31:0];
        set_nz = sf_q;
        set_c  = sf_q;
        set_v  = sf_q;
      end
      OP_CMP_IMM, OP_CMP_REG, OP_CMN: begin
        val    = add_sum[31:0];
        write  = 1'b0;
        set_nz = 1'b1;
        set_c  = 1'b1;
        set_v  = 1'b1;
      end
      OP_ADD_REG_HI, OP_ADR, OP_ADD_SP_IMM: begin
        val = add_sum[31:0];
      end
      OP_ADD_SP_SP, OP_SUB_SP_IMM: begin
        val   = add_sum[31:0];
        to_sp = 1'b1;
      end
      OP_AND: begin
        val    = a & b;
        set_nz = sf_q;
      end
      OP_EOR: begin
        val    = a ^ b;
        set_nz = sf_q;
      end
      OP_ORR: begin
        val    = a | b;
        set_nz = sf_q;
      end
      OP_BIC: begin
        val    = a & ~b;
        set_nz = sf_q;
      end
      OP_MVN: begin
        val    = ~b;
        set_nz = sf_q;
      end
      OP_TST: begin
        val    = a & b;
        write  = 1'b0;
        set_nz = 1'b1;
      end
      OP_MUL: begin
        val    = mul_lo;
        set_nz = sf_q;
      end
      OP_SXTB: val = {{24{b[7]}}, b[7:0]};
      OP_SXTH: val = {{16{b[15]}}, b[15:0]};
      OP_UXTB: val = b & ByteMask;
      OP_UXTH: val = b & HalfMask;
      OP_REV: val = {b[7:0], b[15:8], b[23:16], b[31:24]};
      OP_REV16: val = ((b & HalfLanes) << 8) | ((b >> 8) & HalfLanes);
      OP_REVSH: val = {{16{b[7]}}, b[7:0], b[15:8]};
      default: begin
        write = 1'b0;
        known = 1'b0;
      end
    endcase
  end

  always_comb begin
    flags_d = flags_q;
    if (known) begin
      if (set_nz) begin
        flags_d.n = val[31];
        flags_d.z = (val == '0);
      end
      if (set_c) begin
        flags_d.c = (op_q <= OP_ROR_REG) ? sh_c : add_sum[32];
      end
      if (set_v) begin
        flags_d.v = add_v;
      end
    end
  end

  always_comb begin
    res_d   = val;
    pcw_d   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = rd_q;
    wr_data = val;
    if (!write) begin
      res_d = '0;
    end else if (to_sp) begin
      wr_en   = advance;
      wr_addr = SpIdx;
    end else if (rd_q == PcIdx) begin
      res_d = {val[31:1], 1'b0};
      pcw_d = 1'b1;
    end else begin
      wr_en = advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q    <= res_d;
      flags_out_q <= flags_d;
      pcw_q       <= pcw_d;
      status_q    <= known ? ST_OK : ST_UNDEF;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;
  assign flags_out_o    = flags_out_q;
  assign pc_written_o   = pcw_q;
  assign exec_status_o  = status_q;

  `TDPE_ASSERT_NOW(a_fire_retires, in_fire && s1_valid_q, advance)
  `TDPE_ASSERT_NOW(a_pc_target_even, out_valid_o && pc_written_o, !result_value_o[0])
  `TDPE_ASSERT_NOW(a_undef_quiet, out_valid_o && exec_status_o,
                   (result_value_o == '0) && !pc_written_o)
  `TDPE_ASSERT_NEXT(a_stall_holds_flags, s1_valid_q && !advance, $stable(flags_q))

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import tdpe_pkg::*;

  localparam int StallLimit = 2000;
  localparam int ItemsPerPhase = 225;

  typedef struct packed {
    logic        c;
    logic [31:0] value;
  } shift_t;

  typedef struct packed {
    logic        v;
    logic        c;
    logic [31:0] sum;
  } sum_t;

  typedef struct {
    logic [31:0] value;
    flags_t      flags;
    logic        pc_wr;
    status_e     status;
  } exec_result_t;

  class exec_scoreboard;
    logic [31:0]  regs [NumRegs];
    flags_t       flags;
    exec_result_t pending_results [$];
    int           mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      flags = '0;
      mismatches = 0;
    endfunction

    function logic [31:0] operand_of(logic [3:0] idx, logic [31:0] pc);
      if (idx == PcIdx) return pc + 32'd4;
      return regs[idx];
    endfunction

    function shift_t shift_c(logic [31:0] x, shift_e kind, logic [31:0] amt, logic cin);
      shift_t      r;
      logic [63:0] dbl;
      r.value = x;
      r.c = cin;
      if (amt != 0) begin
        case (kind)
          SH_LSL: begin
            if (amt < 32) begin
              r.value = x << amt;
              r.c = x[32 - amt];
            end else begin
              r.value = '0;
              r.c = (amt == 32) ? x[0] : 1'b0;
            end
          end
          SH_LSR: begin
            if (amt < 32) begin
              r.value = x >> amt;
              r.c = x[amt - 1];
            end else begin
              r.value = '0;
              r.c = (amt == 32) ? x[31] : 1'b0;
            end
          end
          SH_ASR: begin
            if (amt < 32) begin
              r.value = $signed(x) >>> amt;
              r.c = x[amt - 1];
            end else begin
              r.value = {32{x[31]}};
              r.c = x[31];
            end
          end
          default: begin
            dbl = {x, x} >> amt[4:0];
            r.value = dbl[31:0];
            r.c = r.value[31];
          end
        endcase
      end
      return r;
    endfunction

    function sum_t add_c(logic [31:0] a, logic [31:0] b, logic cin);
      sum_t        r;
      logic [32:0] t;
      logic [31:0] ov;
      t = {1'b0, a} + {1'b0, b} + {32'd0, cin};
      ov = (a ^ t[31:0]) & (b ^ t[31:0]);
      r.sum = t[31:0];
      r.c = t[32];
      r.v = ov[31];
      return r;
    endfunction

    function void note_instr(logic [5:0] opcode, logic [3:0] rd, logic [3:0] rn,
                             logic [3:0] rm, logic [31:0] imm, logic sf, logic [31:0] pc);
      logic [31:0]  a, b, val;
      logic         c_new, v_new;
      bit           dest_wr, set_nz, set_c, set_v, to_sp, known, is_shift, is_sum, is_cmp;
      shift_t       sh;
      sum_t         s;
      exec_result_t want;
      a = operand_of(rn, pc);
      b = operand_of(rm, pc);
      val = '0;
      c_new = flags.c;
      v_new = flags.v;
      dest_wr = 1;
      set_nz = 0;
      set_c = 0;
      set_v = 0;
      to_sp = 0;
      known = 1;
      is_shift = 0;
      is_sum = 0;
      is_cmp = 0;
      sh = '0;
      s = '0;
      case (opcode)
        OP_MOV_IMM: begin
          val = imm;
          set_nz = sf;
        end
        OP_MOV_REG: begin
          val = b;
          set_nz = sf;
        end
        OP_MOV_REG_HI: val = b;
        OP_LSL_IMM: begin
          sh = shift_c(b, SH_LSL, imm, flags.c);
          is_shift = 1;
        end
        OP_LSR_IMM: begin
          sh = shift_c(b, SH_LSR, (imm == 0) ? 32'd32 : imm, flags.c);
          is_shift = 1;
        end
        OP_ASR_IMM: begin
          sh = shift_c(b, SH_ASR, (imm == 0) ? 32'd32 : imm, flags.c);
          is_shift = 1;
        end
        OP_LSL_REG: begin
          sh = shift_c(a, SH_LSL, {24'd0, b[7:0]}, flags.c);
          is_shift = 1;
        end
        OP_LSR_REG: begin
          sh = shift_c(a, SH_LSR, {24'd0, b[7:0]}, flags.c);
          is_shift = 1;
        end
        OP_ASR_REG: begin
          sh = shift_c(a, SH_ASR, {24'd0, b[7:0]}, flags.c);
          is_shift = 1;
        end
        OP_ROR_REG: begin
          sh = shift_c(a, SH_ROR, {24'd0, b[7:0]}, flags.c);
          is_shift = 1;
        end
        OP_ADD_REG: begin
          s = add_c(a, b, 1'b0);
          is_sum = 1;
        end
        OP_ADD_IMM: begin
          s = add_c(a, imm, 1'b0);
          is_sum = 1;
        end
        OP_SUB_REG: begin
          s = add_c(a, ~b, 1'b1);
          is_sum = 1;
        end
        OP_SUB_IMM: begin
          s = add_c(a, ~imm, 1'b1);
          is_sum = 1;
        end
        OP_ADC: begin
          s = add_c(a, b, flags.c);
          is_sum = 1;
        end
        OP_SBC: begin
          s = add_c(a, ~b, flags.c);
          is_sum = 1;
        end
        OP_RSB: begin
          s = add_c(~a, 32'd0, 1'b1);
          is_sum = 1;
        end
        OP_CMP_IMM: begin
          s = add_c(a, ~imm, 1'b1);
          is_sum = 1;
          is_cmp = 1;
        end
        OP_CMP_REG: begin
          s = add_c(a, ~b, 1'b1);
          is_sum = 1;
          is_cmp = 1;
        end
        OP_CMN: begin
          s = add_c(a, b, 1'b0);
          is_sum = 1;
          is_cmp = 1;
        end
        OP_ADD_REG_HI: val = a + b;
        OP_AND: begin
          val = a & b;
          set_nz = sf;
        end
        OP_EOR: begin
          val = a ^ b;
          set_nz = sf;
        end
        OP_ORR: begin
          val = a | b;
          set_nz = sf;
        end
        OP_BIC: begin
          val = a & ~b;
          set_nz = sf;
        end
        OP_MVN: begin
          val = ~b;
          set_nz = sf;
        end
        OP_TST: begin
          val = a & b;
          set_nz = 1;
          dest_wr = 0;
        end
        OP_MUL: begin
          val = a * b;
          set_nz = sf;
        end
        OP_ADR: val = ((pc + 32'd4) & ~32'd3) + imm;
        OP_ADD_SP_IMM: val = regs[SpIdx] + imm;
        OP_ADD_SP_SP: begin
          val = regs[SpIdx] + imm;
          to_sp = 1;
        end
        OP_SUB_SP_IMM: begin
          val = regs[SpIdx] - imm;
          to_sp = 1;
        end
        OP_SXTB: val = {{24{b[7]}}, b[7:0]};
        OP_SXTH: val = {{16{b[15]}}, b[15:0]};
        OP_UXTB: val = {24'd0, b[7:0]};
        OP_UXTH: val = {16'd0, b[15:0]};
        OP_REV: val = {b[7:0], b[15:8], b[23:16], b[31:24]};
        OP_REV16: val = {b[23:16], b[31:24], b[7:0], b[15:8]};
        OP_REVSH: val = {{16{b[7]}}, b[7:0], b[15:8]};
        default: known = 0;
      endcase

      if (!known) begin
        want.value = '0;
        want.flags = flags;
        want.pc_wr = 1'b0;
        want.status = ST_UNDEF;
        pending_results.push_back(want);
        return;
      end

      if (is_shift) begin
        val = sh.value;
        c_new = sh.c;
        set_nz = sf;
        set_c = sf;
      end
      if (is_sum) begin
        val = s.sum;
        c_new = s.c;
        v_new = s.v;
        if (is_cmp) begin
          dest_wr = 0;
          set_nz = 1;
          set_c = 1;
          set_v = 1;
        end else begin
          set_nz = sf;
          set_c = sf;
          set_v = sf;
        end
      end

      if (set_nz) begin
        flags.n = val[31];
        flags.z = (val == 0);
      end
      if (set_c) flags.c = c_new;
      if (set_v) flags.v = v_new;

      want.pc_wr = 1'b0;
      if (!dest_wr) begin
        val = '0;
      end else if (to_sp) begin
        regs[SpIdx] = val;
      end else if (rd == PcIdx) begin
        val[0] = 1'b0;
        want.pc_wr = 1'b1;
      end else begin
        regs[rd] = val;
      end
      want.value = val;
      want.flags = flags;
      want.status = ST_OK;
      pending_results.push_back(want);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [31:0] value, logic [3:0] flags_bits, logic pc_wr, logic status);
      exec_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending: value=%h", value));
        return;
      end
      want = pending_results.pop_front();
      if (value !== want.value)
        report($sformatf("result_value %h, want %h", value, want.value));
      if (flags_bits !== want.flags)
        report($sformatf("flags_out %b, want %b", flags_bits, want.flags));
      if (pc_wr !== want.pc_wr)
        report($sformatf("pc_written %b, want %b", pc_wr, want.pc_wr));
      if (status !== want.status)
        report($sformatf("exec_status %b, want %b", status, want.status));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [5:0]  opcode_i;
  logic [3:0]  dest_reg_i;
  logic [3:0]  first_reg_i;
  logic [3:0]  second_reg_i;
  logic [31:0] immediate_i;
  logic        update_flags_i;
  logic [31:0] instr_address_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] result_value_o;
  logic [3:0]  flags_out_o;
  logic        pc_written_o;
  logic        exec_status_o;

  exec_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int idle_cycles = 0;

  thumb_data_processing_execute_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .dest_reg_i     (dest_reg_i),
    .first_reg_i    (first_reg_i),
    .second_reg_i   (second_reg_i),
    .immediate_i    (immediate_i),
    .update_flags_i (update_flags_i),
    .instr_address_i(instr_address_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o),
    .flags_out_o    (flags_out_o),
    .pc_written_o   (pc_written_o),
    .exec_status_o  (exec_status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_instr(opcode_i, dest_reg_i, first_reg_i, second_reg_i, immediate_i,
                    update_flags_i, instr_address_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(result_value_o, flags_out_o, pc_written_o, exec_status_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send_instr(input logic [5:0] op, input logic [3:0] rd, input logic [3:0] rn,
                            input logic [3:0] rm, input logic [31:0] imm, input logic sf,
                            input logic [31:0] pc);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    opcode_i = op;
    dest_reg_i = rd;
    first_reg_i = rn;
    second_reg_i = rm;
    immediate_i = imm;
    update_flags_i = sf;
    instr_address_i = pc;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    logic [5:0]  op;
    logic [31:0] imm;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 5) op = 6'($urandom_range(63, 39));
    else if (pick < 20) op = OP_MOV_IMM;
    else op = 6'($urandom_range(38));
    case ($urandom_range(3))
      0: imm = $urandom_range(40);
      1: imm = $urandom;
      2: begin
        case ($urandom_range(4))
          0: imm = 32'h0;
          1: imm = 32'h1;
          2: imm = 32'h7FFF_FFFF;
          3: imm = 32'h8000_0000;
          default: imm = 32'hFFFF_FFFF;
        endcase
      end
      default: imm = $urandom_range(255);
    endcase
    if ((op == OP_LSL_IMM || op == OP_LSR_IMM || op == OP_ASR_IMM) && $urandom_range(1))
      imm = $urandom_range(33);
    send_instr(op, 4'($urandom_range(15)), 4'($urandom_range(15)), 4'($urandom_range(15)),
               imm, 1'($urandom_range(1)), $urandom);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = '0;
    dest_reg_i = '0;
    first_reg_i = '0;
    second_reg_i = '0;
    immediate_i = '0;
    update_flags_i = 1'b0;
    instr_address_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_instr(OP_MOV_IMM, 4'd0, 4'd0, 4'd0, 32'hFFFF_FFFF, 1'b1, 32'h0000_1000);
    send_instr(OP_MOV_IMM, 4'd1, 4'd0, 4'd0, 32'h0, 1'b1, 32'h0000_1002);
    send_instr(OP_MOV_IMM, 4'd2, 4'd0, 4'd0, 32'h8000_0000, 1'b0, 32'h0000_1004);
    send_instr(OP_MOV_IMM, 4'd3, 4'd0, 4'd0, 32'd32, 1'b0, 32'h0000_1006);
    send_instr(OP_MOV_IMM, 4'd4, 4'd0, 4'd0, 32'd33, 1'b0, 32'h0000_1008);
    send_instr(OP_MOV_IMM, 4'd5, 4'd0, 4'd0, 32'd1, 1'b0, 32'h0000_100A);
    send_instr(OP_LSL_IMM, 4'd6, 4'd0, 4'd0, 32'd0, 1'b1, 32'h0000_100C);
    send_instr(OP_LSR_IMM, 4'd6, 4'd0, 4'd2, 32'd0, 1'b1, 32'h0000_100E);
    send_instr(OP_ASR_IMM, 4'd7, 4'd0, 4'd2, 32'd0, 1'b1, 32'h0000_1010);
    send_instr(OP_LSL_REG, 4'd8, 4'd0, 4'd3, 32'd0, 1'b1, 32'h0000_1012);
    send_instr(OP_LSR_REG, 4'd8, 4'd0, 4'd4, 32'd0, 1'b1, 32'h0000_1014);
    send_instr(OP_ASR_REG, 4'd9, 4'd2, 4'd4, 32'd0, 1'b1, 32'h0000_1016);
    send_instr(OP_ROR_REG, 4'd9, 4'd0, 4'd3, 32'd0, 1'b1, 32'h0000_1018);
    send_instr(OP_ADD_REG, 4'd10, 4'd0, 4'd5, 32'd0, 1'b1, 32'h0000_101A);
    send_instr(OP_ADD_IMM, 4'd10, 4'd2, 4'd0, 32'h8000_0000, 1'b1, 32'h0000_101C);
    send_instr(OP_SBC, 4'd11, 4'd1, 4'd5, 32'd0, 1'b1, 32'h0000_101E);
    send_instr(OP_RSB, 4'd11, 4'd2, 4'd0, 32'd0, 1'b1, 32'h0000_1020);
    send_instr(OP_CMP_IMM, 4'd0, 4'd1, 4'd0, 32'd1, 1'b0, 32'h0000_1022);
    send_instr(OP_CMN, 4'd0, 4'd0, 4'd5, 32'd0, 1'b0, 32'h0000_1024);
    send_instr(OP_TST, 4'd0, 4'd0, 4'd1, 32'd0, 1'b0, 32'h0000_1026);
    send_instr(OP_MOV_REG_HI, PcIdx, 4'd0, 4'd0, 32'd0, 1'b0, 32'h0000_1028);
    send_instr(OP_MOV_REG, 4'd12, 4'd0, PcIdx, 32'd0, 1'b1, 32'hFFFF_FFFE);
    send_instr(OP_ADD_SP_SP, 4'd0, 4'd0, 4'd0, 32'h0000_0400, 1'b0, 32'h0000_102C);
    send_instr(OP_SUB_SP_IMM, 4'd5, 4'd0, 4'd0, 32'h0000_0800, 1'b0, 32'h0000_102E);
    send_instr(OP_ADR, 4'd14, 4'd0, 4'd0, 32'h0000_03FC, 1'b0, 32'h0000_1032);
    send_instr(6'd63, 4'd15, 4'd15, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 47; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 47; end
        default: begin send_idle = 27; recv_stall = 27; end
      endcase
      repeat (ItemsPerPhase) send_random();
    end
    in_valid_i = 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
